FILE: rtl/sbf_pkg.sv
// Shared types, register map and arithmetic constants for the scheduled brightness fader.
// No dependencies; every other file refers to this package by scoped names.

package sbf_pkg;

  // register map: register i at byte address 4*i
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [2:0] REG_PRIMARY_LEVEL   = 3'd0;
  localparam logic [2:0] REG_SECONDARY_LEVEL = 3'd1;
  localparam logic [2:0] REG_SECONDARY_MODE  = 3'd2;
  localparam logic [2:0] REG_WINDOW_START    = 3'd3;
  localparam logic [2:0] REG_WINDOW_END      = 3'd4;
  localparam logic [2:0] REG_LIMIT_JACK      = 3'd5;
  localparam logic [2:0] REG_LIMIT_USB       = 3'd6;

  // secondary_mode codes; the unused code behaves as off
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_WINDOW = 2'd1;
  localparam logic [1:0] MODE_NIGHT  = 2'd2;

  localparam logic [7:0]  PRIMARY_RESET   = 8'd255;
  localparam logic [7:0]  SECONDARY_RESET = 8'd32;
  localparam logic [13:0] LIMIT_JACK_RESET = 14'd8000;
  localparam logic [13:0] LIMIT_USB_RESET  = 14'd3000;

  // 0.1 in Q0.16; 0.9 is 65536 minus this
  localparam logic signed [14:0] FADE_TAKE_Q16 = 15'sd6554;
  localparam logic [33:0]        FADE_ROUND    = 34'd32768;
  localparam logic signed [16:0] SNAP_LIMIT    = 17'sd256;

  // floor(s/60) for s < 2^17 as (s * 139811) >> 23
  localparam logic [17:0] MIN_RECIP  = 18'd139811;
  localparam int unsigned MIN_SHIFT  = 23;

  typedef struct packed {
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic       visible;
    logic       is_night;
    logic       jack_present;
  } sbf_in_t;

  typedef struct packed {
    logic [7:0]  brightness_out;
    logic [13:0] current_limit_ma;
    logic        in_secondary;
  } sbf_out_t;

  // live configuration as seen by the schedule stage
  typedef struct packed {
    logic [7:0]  primary_level;
    logic [7:0]  secondary_level;
    logic [1:0]  secondary_mode;
    logic [11:0] start_min;
    logic [11:0] end_min;
    logic [13:0] limit_jack_ma;
    logic [13:0] limit_usb_ma;
  } sbf_cfg_t;

  // schedule stage register contents handed to the fade stage
  typedef struct packed {
    logic [7:0]  target;
    logic [13:0] limit_ma;
    logic        in_secondary;
  } sbf_sched_t;

  function automatic logic [11:0] sec_to_min(input logic [16:0] secs);
    logic [34:0] prod;
    prod = {18'd0, secs} * {17'd0, MIN_RECIP};
    return prod[34:MIN_SHIFT];
  endfunction

endpackage

FILE: rtl/sbf_cfg.sv
// Configuration register file behind the APB-style port.
// Depends on sbf_pkg; keeps window bounds both in seconds (readback) and minutes.

module sbf_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sbf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sbf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sbf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output sbf_pkg::sbf_cfg_t              cfg
);

  logic [7:0]  primary_r;
  logic [7:0]  secondary_r;
  logic [1:0]  mode_r;
  logic [16:0] start_sec_r;
  logic [16:0] end_sec_r;
  logic [11:0] start_min_r;
  logic [11:0] end_min_r;
  logic [13:0] limit_jack_r;
  logic [13:0] limit_usb_r;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // minutes are derived at write time so they are valid with the seconds value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primary_r    <= sbf_pkg::PRIMARY_RESET;
      secondary_r  <= sbf_pkg::SECONDARY_RESET;
      mode_r       <= sbf_pkg::MODE_OFF;
      start_sec_r  <= '0;
      end_sec_r    <= '0;
      start_min_r  <= '0;
      end_min_r    <= '0;
      limit_jack_r <= sbf_pkg::LIMIT_JACK_RESET;
      limit_usb_r  <= sbf_pkg::LIMIT_USB_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        sbf_pkg::REG_PRIMARY_LEVEL:   primary_r   <= pwdata[7:0];
        sbf_pkg::REG_SECONDARY_LEVEL: secondary_r <= pwdata[7:0];
        sbf_pkg::REG_SECONDARY_MODE:  mode_r      <= pwdata[1:0];
        sbf_pkg::REG_WINDOW_START: begin
          start_sec_r <= pwdata[16:0];
          start_min_r <= sbf_pkg::sec_to_min(pwdata[16:0]);
        end
        sbf_pkg::REG_WINDOW_END: begin
          end_sec_r <= pwdata[16:0];
          end_min_r <= sbf_pkg::sec_to_min(pwdata[16:0]);
        end
        sbf_pkg::REG_LIMIT_JACK:      limit_jack_r <= pwdata[13:0];
        sbf_pkg::REG_LIMIT_USB:       limit_usb_r  <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      sbf_pkg::REG_PRIMARY_LEVEL:   prdata = {24'd0, primary_r};
      sbf_pkg::REG_SECONDARY_LEVEL: prdata = {24'd0, secondary_r};
      sbf_pkg::REG_SECONDARY_MODE:  prdata = {30'd0, mode_r};
      sbf_pkg::REG_WINDOW_START:    prdata = {15'd0, start_sec_r};
      sbf_pkg::REG_WINDOW_END:      prdata = {15'd0, end_sec_r};
      sbf_pkg::REG_LIMIT_JACK:      prdata = {18'd0, limit_jack_r};
      sbf_pkg::REG_LIMIT_USB:       prdata = {18'd0, limit_usb_r};
      default:                      prdata = '0;
    endcase
  end

  assign cfg.primary_level   = primary_r;
  assign cfg.secondary_level = secondary_r;
  assign cfg.secondary_mode  = mode_r;
  assign cfg.start_min       = start_min_r;
  assign cfg.end_min         = end_min_r;
  assign cfg.limit_jack_ma   = limit_jack_r;
  assign cfg.limit_usb_ma    = limit_usb_r;

endmodule

FILE: rtl/sbf_sched.sv
// Input stage: window / night decision, target pick and supply limit, registered.
// Depends on sbf_pkg; feeds sbf_fade through a valid/advance pair.

module sbf_sched (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sbf_pkg::sbf_in_t     in_data,
  input  sbf_pkg::sbf_cfg_t    cfg,
  input  logic                 advance,
  output logic                 s1_valid,
  output sbf_pkg::sbf_sched_t  s1_data
);

  logic                valid_r;
  logic                valid_nxt;
  sbf_pkg::sbf_sched_t data_r;
  sbf_pkg::sbf_sched_t data_nxt;

  logic [10:0] now_min;
  logic [11:0] now_ext;
  logic        win_hit;
  logic        sec;
  logic        accept;

  // hour*60 as hour*64 - hour*4
  assign now_min = {in_data.hour_now, 6'd0} - 11'({in_data.hour_now, 2'd0})
                   + 11'(in_data.minute_now);
  assign now_ext = {1'b0, now_min};

  always_comb begin
    if (cfg.start_min <= cfg.end_min) begin
      win_hit = (now_ext >= cfg.start_min) && (now_ext < cfg.end_min);
    end else begin
      win_hit = (now_ext >= cfg.start_min) || (now_ext < cfg.end_min);
    end
  end

  always_comb begin
    unique case (cfg.secondary_mode)
      sbf_pkg::MODE_WINDOW: sec = win_hit;
      sbf_pkg::MODE_NIGHT:  sec = in_data.is_night;
      default:              sec = 1'b0;
    endcase
  end

  always_comb begin
    data_nxt.in_secondary = sec;
    data_nxt.limit_ma     = in_data.jack_present ? cfg.limit_jack_ma : cfg.limit_usb_ma;
    if (!in_data.visible) begin
      data_nxt.target = '0;
    end else begin
      data_nxt.target = sec ? cfg.secondary_level : cfg.primary_level;
    end
  end

  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= data_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule

FILE: rtl/sbf_fade.sv
// Fade stage: Q8.8 level update with 0.9/0.1 weights, snap, and the result register.
// Depends on sbf_pkg; takes requests from sbf_sched.

module sbf_fade (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  sbf_pkg::sbf_sched_t  s1_data,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sbf_pkg::sbf_out_t    out_data
);

  logic [15:0]       level_r;
  logic [15:0]       level_nxt;
  logic              out_valid_r;
  sbf_pkg::sbf_out_t out_data_r;

  logic [15:0]        target_q;
  logic signed [16:0] step_diff;
  logic signed [31:0] step_prod;
  logic [33:0]        acc;
  logic [15:0]        blend;
  logic signed [16:0] gap;
  logic               snap;

  assign target_q = {s1_data.target, 8'd0};

  // level*0.9 + target*0.1 rewritten as level + (target - level)*0.1
  assign step_diff = $signed({1'b0, target_q}) - $signed({1'b0, level_r});
  assign step_prod = step_diff * sbf_pkg::FADE_TAKE_Q16;
  assign acc       = {2'd0, level_r, 16'd0} + {{2{step_prod[31]}}, step_prod}
                     + sbf_pkg::FADE_ROUND;
  assign blend     = acc[31:16];

  assign gap  = $signed({1'b0, blend}) - $signed({1'b0, target_q});
  assign snap = (gap > -sbf_pkg::SNAP_LIMIT) && (gap < sbf_pkg::SNAP_LIMIT);
  assign level_nxt = snap ? target_q : blend;

  assign advance = s1_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      level_r     <= level_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.brightness_out   <= level_nxt[15:8];
      out_data_r.current_limit_ma <= s1_data.limit_ma;
      out_data_r.in_secondary     <= s1_data.in_secondary;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/scheduled_brightness_fader.sv
// Top level of the scheduled brightness fader: config registers, schedule stage, fade stage.
// Depends on sbf_pkg, sbf_cfg, sbf_sched and sbf_fade.
//
//   channel | ports                          | carries
//   --------+--------------------------------+-----------------------------------------
//   in      | in_valid, in_stall, in_data    | hour, minute, visible, night, jack flags
//   out     | out_valid, out_stall, out_data | brightness, current limit, secondary flag
//   config  | psel..pready, 32-bit data      | seven registers at byte address 4*i
//
// One request per cycle sustained while out_stall is low; a result passes through the
// schedule stage register and the fade result register on its way to the outputs.
// The rate is set by the fade loop: the level register feeds one multiply-add per cycle.
// Synchronous active-low reset clears the level and both valid flags, no clearing pass.
// A stalled output holds its result; the schedule stage still takes one more request.

module scheduled_brightness_fader (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sbf_pkg::sbf_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sbf_pkg::sbf_out_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sbf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sbf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sbf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  sbf_pkg::sbf_cfg_t   cfg;
  sbf_pkg::sbf_sched_t s1_data;
  logic                s1_valid;
  logic                advance;

  sbf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbf_sched u_sched (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  sbf_fade u_fade (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
